// File: rtl/cdvrm_pkg.sv
// shared types and constants for the cd audio volume and route mixer
// used by cdvrm_ctrl, cdvrm_dp and the top level; depends on nothing

package cdvrm_pkg;

    localparam int SMP_W   = 16;
    localparam int DVOL_W  = 8;
    localparam int CVOL_W  = 16;
    localparam int ROUTE_W = 2;
    localparam int PROD_W  = SMP_W + DVOL_W + 1;      // signed sample x unsigned drive volume
    localparam int SUM_W   = PROD_W + 1;              // two routed products
    localparam int MAG_W   = SMP_W + DVOL_W;          // |routed sum| fits in 24 bits
    localparam int REM_W   = MAG_W + CVOL_W;          // magnitude x card volume
    localparam int QUO_W   = SMP_W - 1;               // quotient magnitude stays below 2^15

    // divide by 511 * 65535: estimate from the top 24 numerator bits times
    // floor(2^40 / divisor), then correct by at most two divisors
    localparam logic [REM_W-1:0] VOL_DIVISOR = REM_W'(33488385);
    localparam int EST_IN_LO = 16;
    localparam int EST_SHIFT = 24;
    localparam int RECIP_W   = 16;
    localparam logic [RECIP_W-1:0] VOL_RECIP = RECIP_W'(32832);

    // residue after the estimate stays below three divisors
    localparam int RES_W = 27;
    localparam logic [RES_W-1:0] DIV_ONE   = RES_W'(33488385);
    localparam logic [RES_W-1:0] DIV_TWO   = RES_W'(66976770);
    localparam logic [RES_W-1:0] DIV_THREE = RES_W'(100465155);

    localparam logic [CVOL_W-1:0] CARD_VOL_RESET = '1;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_CARD_VOL_LEFT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_CARD_VOL_RIGHT = 1'b1;

    localparam int IN_DATA_W  = 56;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 32;

    typedef struct packed {
        logic load;       // capture the input item
        logic mul;        // sample x drive volume
        logic route;      // route sums and magnitude
        logic scale;      // magnitude x card volume
        logic est;        // reciprocal quotient estimate
        logic rem;        // residue after the estimate
        logic fix;        // add back up to two to the quotient
        logic acc;        // accumulate and emit
    } cmd_t;

    typedef struct packed {
        logic acc_block;  // last item but output slot still full
    } status_t;

endpackage

// File: rtl/cd_audio_volume_route_mixer_top.sv
// a result appears on the master side once its last item is accepted and the sequencer has
// stepped through multiply, route, card volume scale, reciprocal estimate, residue and
// correction to the accumulate; no new item is taken before the accumulate step is done
// a held result stalls only a following last item at its accumulate step
// reset (rst_n low, asynchronous): accumulators to zero, card volumes to 65535, no result
// holds the sequencer cdvrm_ctrl and datapath cdvrm_dp; uses cdvrm_pkg

module cd_audio_volume_route_mixer_top (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [cdvrm_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [cdvrm_pkg::CVOL_W-1:0]           cfg_data,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // sample_left, sample_right, drive_vol_left, drive_vol_right,
    // route_src_left, route_src_right, zero fill
    input  logic [cdvrm_pkg::IN_DATA_W-1:0]        s_axis_tdata,
    // audio_present, first_drive
    input  logic [cdvrm_pkg::IN_USER_W-1:0]        s_axis_tuser,
    // last_drive
    input  logic                                   s_axis_tlast,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // mix_left, mix_right
    output logic [cdvrm_pkg::OUT_DATA_W-1:0]       m_axis_tdata
);

    cdvrm_pkg::cmd_t    cmd;
    cdvrm_pkg::status_t status;

    cdvrm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    cdvrm_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (s_axis_tdata),
        .in_user   (s_axis_tuser),
        .in_last   (s_axis_tlast),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

// File: rtl/cdvrm_ctrl.sv
// sequencer for the cd audio mixer: walks one item through multiply,
// route, scale, divide and accumulate; uses cdvrm_pkg

module cdvrm_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  cdvrm_pkg::status_t status,
    output cdvrm_pkg::cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ROUTE,
        ST_SCALE,
        ST_EST,
        ST_REM,
        ST_FIX,
        ST_ACC
    } state_t;

    state_t                           state_reg;
    state_t                           state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_ROUTE;
            end
            ST_ROUTE:
            begin
                cmd.route  = 1'b1;
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = ST_EST;
            end
            ST_EST:
            begin
                cmd.est    = 1'b1;
                state_next = ST_REM;
            end
            ST_REM:
            begin
                cmd.rem    = 1'b1;
                state_next = ST_FIX;
            end
            ST_FIX:
            begin
                cmd.fix    = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                if (!status.acc_block)
                begin
                    cmd.acc    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) $onehot0(cmd))
        else $error("cdvrm_ctrl: more than one command at once");

    assert property (@(posedge clk) disable iff (!rst_n) cmd.est |=> cmd.rem)
        else $error("cdvrm_ctrl: quotient estimate not followed by residue step");

    assert property (@(posedge clk) disable iff (!rst_n) cmd.load |=> cmd.mul)
        else $error("cdvrm_ctrl: accepted item not followed by multiply");

endmodule

// File: rtl/cdvrm_dp.sv
// datapath for the cd audio mixer: card volume registers, multipliers,
// reciprocal divide by 511*65535, accumulators and output register; uses cdvrm_pkg

module cdvrm_dp (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [cdvrm_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [cdvrm_pkg::CVOL_W-1:0]           cfg_data,
    input  logic [cdvrm_pkg::IN_DATA_W-1:0]        in_data,
    input  logic [cdvrm_pkg::IN_USER_W-1:0]        in_user,
    input  logic                                   in_last,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [cdvrm_pkg::OUT_DATA_W-1:0]       out_data,
    input  cdvrm_pkg::cmd_t                        cmd,
    output cdvrm_pkg::status_t                     status
);

    logic [cdvrm_pkg::CVOL_W-1:0]         cvol_l_reg;
    logic [cdvrm_pkg::CVOL_W-1:0]         cvol_r_reg;

    logic signed [cdvrm_pkg::SMP_W-1:0]   smp_l_reg;
    logic signed [cdvrm_pkg::SMP_W-1:0]   smp_r_reg;
    logic [cdvrm_pkg::DVOL_W-1:0]         dvol_l_reg;
    logic [cdvrm_pkg::DVOL_W-1:0]         dvol_r_reg;
    logic [cdvrm_pkg::ROUTE_W-1:0]        route_l_reg;
    logic [cdvrm_pkg::ROUTE_W-1:0]        route_r_reg;
    logic                                 present_reg;
    logic                                 first_reg;
    logic                                 last_reg;

    logic signed [cdvrm_pkg::PROD_W-1:0]  pl_reg;
    logic signed [cdvrm_pkg::PROD_W-1:0]  pr_reg;
    logic signed [cdvrm_pkg::PROD_W-1:0]  pl_next;
    logic signed [cdvrm_pkg::PROD_W-1:0]  pr_next;

    logic signed [cdvrm_pkg::SUM_W-1:0]   to_l;
    logic signed [cdvrm_pkg::SUM_W-1:0]   to_r;
    logic [cdvrm_pkg::SUM_W-1:0]          abs_l;
    logic [cdvrm_pkg::SUM_W-1:0]          abs_r;
    logic [cdvrm_pkg::MAG_W-1:0]          mag_l_reg;
    logic [cdvrm_pkg::MAG_W-1:0]          mag_r_reg;
    logic                                 neg_l_reg;
    logic                                 neg_r_reg;

    logic [cdvrm_pkg::REM_W-1:0]          num_l_reg;
    logic [cdvrm_pkg::REM_W-1:0]          num_r_reg;
    logic [cdvrm_pkg::REM_W-1:0]          est_prod_l;
    logic [cdvrm_pkg::REM_W-1:0]          est_prod_r;
    logic [cdvrm_pkg::REM_W-1:0]          res_full_l;
    logic [cdvrm_pkg::REM_W-1:0]          res_full_r;
    logic [cdvrm_pkg::RES_W-1:0]          res_l_reg;
    logic [cdvrm_pkg::RES_W-1:0]          res_r_reg;
    logic [cdvrm_pkg::QUO_W-1:0]          quo_l_reg;
    logic [cdvrm_pkg::QUO_W-1:0]          quo_r_reg;

    logic [cdvrm_pkg::SMP_W-1:0]          contrib_l;
    logic [cdvrm_pkg::SMP_W-1:0]          contrib_r;
    logic [cdvrm_pkg::SMP_W-1:0]          acc_l_reg;
    logic [cdvrm_pkg::SMP_W-1:0]          acc_r_reg;
    logic [cdvrm_pkg::SMP_W-1:0]          acc_l_next;
    logic [cdvrm_pkg::SMP_W-1:0]          acc_r_next;

    logic                                 out_valid_reg;
    logic [cdvrm_pkg::OUT_DATA_W-1:0]     out_data_reg;

    // card volume registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cvol_l_reg <= cdvrm_pkg::CARD_VOL_RESET;
            cvol_r_reg <= cdvrm_pkg::CARD_VOL_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                cdvrm_pkg::REG_CARD_VOL_LEFT:  cvol_l_reg <= cfg_data;
                cdvrm_pkg::REG_CARD_VOL_RIGHT: cvol_r_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // input capture
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            smp_l_reg   <= in_data[15:0];
            smp_r_reg   <= in_data[31:16];
            dvol_l_reg  <= in_data[39:32];
            dvol_r_reg  <= in_data[47:40];
            route_l_reg <= in_data[49:48];
            route_r_reg <= in_data[51:50];
            present_reg <= in_user[0];
            first_reg   <= in_user[1];
            last_reg    <= in_last;
        end
    end

    assign pl_next = smp_l_reg * $signed({1'b0, dvol_l_reg});
    assign pr_next = smp_r_reg * $signed({1'b0, dvol_r_reg});

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            pl_reg <= pl_next;
            pr_reg <= pr_next;
        end
    end

    // bit0 of a mask feeds output left, bit1 output right
    always_comb
    begin
        to_l = '0;
        to_r = '0;
        if (route_l_reg[0])
        begin
            to_l = to_l + cdvrm_pkg::SUM_W'(pl_reg);
        end
        if (route_r_reg[0])
        begin
            to_l = to_l + cdvrm_pkg::SUM_W'(pr_reg);
        end
        if (route_l_reg[1])
        begin
            to_r = to_r + cdvrm_pkg::SUM_W'(pl_reg);
        end
        if (route_r_reg[1])
        begin
            to_r = to_r + cdvrm_pkg::SUM_W'(pr_reg);
        end
        abs_l = to_l[cdvrm_pkg::SUM_W-1] ? (~to_l + 1'b1) : to_l;
        abs_r = to_r[cdvrm_pkg::SUM_W-1] ? (~to_r + 1'b1) : to_r;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.route)
        begin
            mag_l_reg <= abs_l[cdvrm_pkg::MAG_W-1:0];
            mag_r_reg <= abs_r[cdvrm_pkg::MAG_W-1:0];
            neg_l_reg <= to_l[cdvrm_pkg::SUM_W-1];
            neg_r_reg <= to_r[cdvrm_pkg::SUM_W-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scale)
        begin
            num_l_reg <= mag_l_reg * cvol_l_reg;
            num_r_reg <= mag_r_reg * cvol_r_reg;
        end
    end

    // estimate never exceeds the true quotient and falls short by at most two
    assign est_prod_l = num_l_reg[cdvrm_pkg::REM_W-1:cdvrm_pkg::EST_IN_LO] * cdvrm_pkg::VOL_RECIP;
    assign est_prod_r = num_r_reg[cdvrm_pkg::REM_W-1:cdvrm_pkg::EST_IN_LO] * cdvrm_pkg::VOL_RECIP;

    assign res_full_l = num_l_reg - cdvrm_pkg::REM_W'(quo_l_reg) * cdvrm_pkg::VOL_DIVISOR;
    assign res_full_r = num_r_reg - cdvrm_pkg::REM_W'(quo_r_reg) * cdvrm_pkg::VOL_DIVISOR;

    always_ff @(posedge clk)
    begin
        if (cmd.est)
        begin
            quo_l_reg <= est_prod_l[cdvrm_pkg::EST_SHIFT+cdvrm_pkg::QUO_W-1:cdvrm_pkg::EST_SHIFT];
            quo_r_reg <= est_prod_r[cdvrm_pkg::EST_SHIFT+cdvrm_pkg::QUO_W-1:cdvrm_pkg::EST_SHIFT];
        end
        else if (cmd.fix)
        begin
            if (res_l_reg >= cdvrm_pkg::DIV_TWO)
            begin
                quo_l_reg <= quo_l_reg + cdvrm_pkg::QUO_W'(2);
            end
            else if (res_l_reg >= cdvrm_pkg::DIV_ONE)
            begin
                quo_l_reg <= quo_l_reg + cdvrm_pkg::QUO_W'(1);
            end
            if (res_r_reg >= cdvrm_pkg::DIV_TWO)
            begin
                quo_r_reg <= quo_r_reg + cdvrm_pkg::QUO_W'(2);
            end
            else if (res_r_reg >= cdvrm_pkg::DIV_ONE)
            begin
                quo_r_reg <= quo_r_reg + cdvrm_pkg::QUO_W'(1);
            end
        end
    end

    // residue is below three divisors, so its low bits carry it exactly
    always_ff @(posedge clk)
    begin
        if (cmd.rem)
        begin
            res_l_reg <= res_full_l[cdvrm_pkg::RES_W-1:0];
            res_r_reg <= res_full_r[cdvrm_pkg::RES_W-1:0];
        end
    end

    // quotient magnitude is at most 32703, so a signed contribution fits in 16 bits
    assign contrib_l = neg_l_reg ? (~{1'b0, quo_l_reg} + 1'b1) : {1'b0, quo_l_reg};
    assign contrib_r = neg_r_reg ? (~{1'b0, quo_r_reg} + 1'b1) : {1'b0, quo_r_reg};

    always_comb
    begin
        acc_l_next = first_reg ? '0 : acc_l_reg;
        acc_r_next = first_reg ? '0 : acc_r_reg;
        if (present_reg)
        begin
            acc_l_next = acc_l_next + contrib_l;
            acc_r_next = acc_r_next + contrib_r;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_l_reg     <= '0;
            acc_r_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.acc)
            begin
                acc_l_reg <= acc_l_next;
                acc_r_reg <= acc_r_next;
            end
            if (cmd.acc && last_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.acc && last_reg)
        begin
            out_data_reg <= {acc_r_next, acc_l_next};
        end
    end

    assign out_valid        = out_valid_reg;
    assign out_data         = out_data_reg;
    assign status.acc_block = last_reg && out_valid_reg && !out_ready;

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fix |-> res_l_reg < cdvrm_pkg::DIV_THREE)
        else $error("cdvrm_dp: left residue out of range, quotient estimate too low");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fix |-> res_r_reg < cdvrm_pkg::DIV_THREE)
        else $error("cdvrm_dp: right residue out of range, quotient estimate too low");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.acc && last_reg |-> !(out_valid_reg && !out_ready))
        else $error("cdvrm_dp: result written over an item not yet taken");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd.acc && last_reg))
        else $error("cdvrm_dp: output valid raised without a last item");

endmodule
